@@ sv/bdsa_pkg.sv @@
// Shared types and constants for the button debounce / setpoint adjust block.
// Debouncer state codes, register map, reset values, configuration struct.
// No dependencies.
package bdsa_pkg;

	typedef enum logic [1:0] {
		DB_RELEASED    = 2'd0,
		DB_PREPRESSED  = 2'd1,
		DB_PRESSED     = 2'd2,
		DB_PRERELEASED = 2'd3
	} db_state_t;

	// register index = paddr[4:2]
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned PaddrW  = RegIdxW + 2;

	typedef enum logic [RegIdxW-1:0] {
		REG_TEMP_STEP   = 3'd0,
		REG_UPPER_LIMIT = 3'd1,
		REG_LOWER_LIMIT = 3'd2,
		REG_IDLE_LIMIT  = 3'd3,
		REG_INIT_SP     = 3'd4
	} reg_idx_t;

	localparam logic [5:0]  RstTempStep  = 6'd5;
	localparam logic [7:0]  RstUpper     = 8'd75;
	localparam logic [7:0]  RstLower     = 8'd35;
	localparam logic [15:0] RstIdleLimit = 16'd250;
	localparam logic [7:0]  RstInitSp    = 8'd60;

	typedef struct packed {
		logic [5:0]  temp_step;
		logic [7:0]  upper_limit;
		logic [7:0]  lower_limit;
		logic [15:0] idle_limit;
	} cfg_t;

endpackage

@@ sv/bdsa_debounce.sv @@
// Four-state two-sample debouncer for one active-low button.
// Depends on bdsa_pkg (db_state_t).
module bdsa_debounce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               level,
	output bdsa_pkg::db_state_t state_nxt
);
	import bdsa_pkg::*;

	db_state_t state_q;
	logic      last_q;

	// next state from previous and current sample
	always_comb begin
		unique case (state_q)
			DB_RELEASED:    state_nxt = (!last_q && !level) ? DB_PREPRESSED : DB_RELEASED;
			DB_PREPRESSED:  state_nxt = (!level) ? DB_PRESSED : DB_PREPRESSED;
			DB_PRESSED:     state_nxt = (last_q && level) ? DB_PRERELEASED : DB_PRESSED;
			DB_PRERELEASED: state_nxt = level ? DB_RELEASED : DB_PRERELEASED;
			default:        state_nxt = DB_RELEASED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DB_RELEASED;
			last_q  <= 1'b0;
		end else if (en) begin
			state_q <= state_nxt;
			last_q  <= level;
		end
	end

endmodule

@@ sv/bdsa_regs.sv @@
// APB-style configuration registers of the setpoint adjuster.
// Depends on bdsa_pkg (cfg_t, register map, reset values).
module bdsa_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdsa_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bdsa_pkg::cfg_t              cfg,
	output logic                        sp_load,
	output logic [7:0]                  sp_load_val
);
	import bdsa_pkg::*;

	cfg_t       cfg_q;
	logic [7:0] init_sp_q;
	logic       wr_en;
	reg_idx_t   idx;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite;
	assign idx         = reg_idx_t'(paddr[PaddrW-1:2]);
	assign sp_load     = wr_en && (idx == REG_INIT_SP);
	assign sp_load_val = pwdata[7:0];
	assign cfg         = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_step   <= RstTempStep;
			cfg_q.upper_limit <= RstUpper;
			cfg_q.lower_limit <= RstLower;
			cfg_q.idle_limit  <= RstIdleLimit;
			init_sp_q         <= RstInitSp;
		end else if (wr_en) begin
			unique case (idx)
				REG_TEMP_STEP:   cfg_q.temp_step   <= pwdata[5:0];
				REG_UPPER_LIMIT: cfg_q.upper_limit <= pwdata[7:0];
				REG_LOWER_LIMIT: cfg_q.lower_limit <= pwdata[7:0];
				REG_IDLE_LIMIT:  cfg_q.idle_limit  <= pwdata[15:0];
				REG_INIT_SP:     init_sp_q         <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TEMP_STEP:   prdata = {26'd0, cfg_q.temp_step};
			REG_UPPER_LIMIT: prdata = {24'd0, cfg_q.upper_limit};
			REG_LOWER_LIMIT: prdata = {24'd0, cfg_q.lower_limit};
			REG_IDLE_LIMIT:  prdata = {16'd0, cfg_q.idle_limit};
			REG_INIT_SP:     prdata = {24'd0, init_sp_q};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/bdsa_ctrl.sv @@
// Setpoint controller: normal/setting mode, idle timeout, setpoint store.
// Depends on bdsa_pkg (db_state_t, cfg_t).
module bdsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bdsa_pkg::db_state_t up_st,
	input  bdsa_pkg::db_state_t dn_st,
	input  bdsa_pkg::cfg_t      cfg,
	input  logic                sp_load,
	input  logic [7:0]          sp_load_val,
	output logic [7:0]          setpoint_nxt,
	output logic                setting_nxt,
	output logic                save_nxt
);
	import bdsa_pkg::*;

	logic        setting_q;
	logic [15:0] idle_q;
	logic [7:0]  sp_q;
	logic [15:0] idle_nxt;
	logic        up_rel;
	logic        dn_rel;
	logic [7:0]  step8;

	assign up_rel = (up_st == DB_PRERELEASED);
	assign dn_rel = (dn_st == DB_PRERELEASED);
	assign step8  = {2'b00, cfg.temp_step};

	always_comb begin
		setting_nxt  = setting_q;
		idle_nxt     = idle_q;
		setpoint_nxt = sp_q;
		save_nxt     = 1'b0;
		if (!setting_q) begin
			setting_nxt = up_rel || dn_rel;
		end else if (idle_q < cfg.idle_limit) begin
			// up wins when both act
			if (up_rel && (sp_q < cfg.upper_limit)) begin
				setpoint_nxt = sp_q + step8;
				idle_nxt     = 16'd0;
			end else if (dn_rel && (sp_q > cfg.lower_limit)) begin
				setpoint_nxt = sp_q - step8;
				idle_nxt     = 16'd0;
			end else begin
				idle_nxt = idle_q + 16'd1;
			end
		end else begin
			// timeout: buttons ignored this tick
			setting_nxt = 1'b0;
			idle_nxt    = 16'd0;
			save_nxt    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= 1'b0;
			idle_q    <= 16'd0;
			sp_q      <= RstInitSp;
		end else if (sp_load) begin
			sp_q <= sp_load_val;
		end else if (en) begin
			setting_q <= setting_nxt;
			idle_q    <= idle_nxt;
			sp_q      <= setpoint_nxt;
		end
	end

endmodule

@@ sv/button_debounce_setpoint_adjust.sv @@
// Debounced two-button setpoint adjuster, top level.
// Each input word is registered in the input reg, then its result word in the result reg.
// Throughput: one word per cycle while out_stall is low; the state update is shallow logic between the regs.
// Reset (arst_n low): debouncers released, normal mode, idle count 0, setpoint 60,
// registers at their defaults, both pipeline stages empty.
// Depends on bdsa_pkg, bdsa_regs, bdsa_debounce, bdsa_ctrl.
module button_debounce_setpoint_adjust (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdsa_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        up_level,
	input  logic                        down_level,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  setpoint,
	output logic                        in_setting,
	output logic                        save_pulse,
	output logic [1:0]                  up_state,
	output logic [1:0]                  down_state
);
	import bdsa_pkg::*;

	// stage 1: registered input word
	logic      valid_s1;
	logic      up_level_s1;
	logic      down_level_s1;
	// stage 2: result register driving the output ports
	logic      valid_s2;
	logic [7:0] setpoint_s2;
	logic      setting_s2;
	logic      save_s2;
	db_state_t up_st_s2;
	db_state_t dn_st_s2;

	logic       adv_s1;   // stage 1 word moves to result reg; state commits
	logic       acc_in;
	cfg_t       cfg;
	logic       sp_load;
	logic [7:0] sp_load_val;
	db_state_t  up_st_nxt;
	db_state_t  dn_st_nxt;
	logic [7:0] sp_nxt;
	logic       setting_nxt;
	logic       save_nxt;

	// result reg frees when empty or when its word is taken this cycle
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign acc_in   = in_valid && !in_stall;

	bdsa_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.sp_load    (sp_load),
		.sp_load_val(sp_load_val)
	);

	bdsa_debounce u_db_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_s1),
		.level    (up_level_s1),
		.state_nxt(up_st_nxt)
	);

	bdsa_debounce u_db_dn (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_s1),
		.level    (down_level_s1),
		.state_nxt(dn_st_nxt)
	);

	// controller sees the debouncer states after this tick
	bdsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv_s1),
		.up_st       (up_st_nxt),
		.dn_st       (dn_st_nxt),
		.cfg         (cfg),
		.sp_load     (sp_load),
		.sp_load_val (sp_load_val),
		.setpoint_nxt(sp_nxt),
		.setting_nxt (setting_nxt),
		.save_nxt    (save_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload regs, no reset
	always_ff @(posedge clk) begin
		if (acc_in) begin
			up_level_s1   <= up_level;
			down_level_s1 <= down_level;
		end
		if (adv_s1) begin
			setpoint_s2 <= sp_nxt;
			setting_s2  <= setting_nxt;
			save_s2     <= save_nxt;
			up_st_s2    <= up_st_nxt;
			dn_st_s2    <= dn_st_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign setpoint   = setpoint_s2;
	assign in_setting = setting_s2;
	assign save_pulse = save_s2;
	assign up_state   = up_st_s2;
	assign down_state = dn_st_s2;

endmodule
